/* src/lrt_pkg.sv */
// ============================================================================
// LRU tracker package
// Shared widths, operation and status codes, state encoding and the beat and
// control structures of the LRU replacement tracker.
// ============================================================================
`default_nettype none

package lrt_pkg;

	localparam int KEY_W         = 32;
	localparam int OP_W          = 2;
	localparam int STATUS_W      = 2;
	localparam int COUNT_W       = 7;
	localparam int CAPACITY_DEF  = 64;
	localparam int KEY_BITS_DEF  = 32;

	localparam logic [OP_W-1:0] OP_TOUCH  = 2'd0;
	localparam logic [OP_W-1:0] OP_VICTIM = 2'd1;
	localparam logic [OP_W-1:0] OP_ERASE  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [KEY_W-1:0]    victim_key;
		logic [COUNT_W-1:0]  count;
	} rsp_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_SCAN_TAIL,
		S_DECIDE,
		S_UPDATE,
		S_UPDATE_TAIL,
		S_RESP
	} state_t;

	typedef struct packed {
		logic clear;
		logic load_item;
		logic scan_rd;
		logic decide;
		logic upd_rd;
		logic load_out;
	} lrt_cmd_t;

	typedef struct packed {
		logic idx_last;
		logic need_update;
		logic out_free;
	} lrt_sts_t;

endpackage

`default_nettype wire

/* src/lrt_ctrl.sv */
// ============================================================================
// LRU tracker controller
// Sequences the clearing sweep, the lookup scan, the age update pass and the
// result beat.
// ============================================================================
`default_nettype none

module lrt_ctrl import lrt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  lrt_sts_t sts,
	output lrt_cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (sts.idx_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.idx_last) begin
					state_d = S_SCAN_TAIL;
				end
			end
			S_SCAN_TAIL: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				state_d = sts.need_update ? S_UPDATE : S_RESP;
			end
			S_UPDATE: begin
				if (sts.idx_last) begin
					state_d = S_UPDATE_TAIL;
				end
			end
			S_UPDATE_TAIL: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
			end
			S_IDLE: begin
				req_ready     = 1'b1;
				cmd.load_item = req_valid;
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
			end
			S_UPDATE: begin
				cmd.upd_rd = 1'b1;
			end
			S_RESP: begin
				cmd.load_out = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

/* src/lrt_dp.sv */
// ============================================================================
// LRU tracker datapath
// Entry memory holding valid bit, recency age and key, with the scan, update
// and result registers.
// ============================================================================
`default_nettype none

module lrt_dp import lrt_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  lrt_cmd_t cmd,
	output lrt_sts_t sts,
	input  req_t     req,
	output rsp_t     rsp,
	output logic     rsp_valid,
	input  logic     rsp_ready
);

	localparam int IDX_W     = $clog2(CAPACITY);
	localparam int AGE_W     = IDX_W;
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int WORD_W    = 1 + AGE_W + KEY_BITS;
	localparam int KEY_EXT_W = (KEY_BITS > KEY_W) ? KEY_BITS : KEY_W;
	localparam int CNT_EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

	logic [WORD_W-1:0]   mem [CAPACITY];

	logic [IDX_W-1:0]    idx_q;
	logic [OP_W-1:0]     op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [CNT_W-1:0]    count_q;
	logic                hit_q;
	logic [IDX_W-1:0]    hit_idx_q;
	logic [AGE_W-1:0]    hit_age_q;
	logic [KEY_BITS-1:0] hit_key_q;
	logic                free_q;
	logic [IDX_W-1:0]    free_idx_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [KEY_W-1:0]    res_vkey_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	logic                scan_s1;
	logic                upd_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [WORD_W-1:0]   rdata_s1;

	logic                idx_last;
	logic                idx_step;
	logic                rd_vld;
	logic [AGE_W-1:0]    rd_age;
	logic [KEY_BITS-1:0] rd_key;
	logic                is_touch;
	logic                is_rem;
	logic [CNT_W-1:0]    cnt_m1;
	logic [AGE_W-1:0]    vict_age;
	logic                match;
	logic                full;
	logic                ins_ok;
	logic                need_update;
	logic                new_vld;
	logic [AGE_W-1:0]    new_age;
	logic [KEY_BITS-1:0] new_key;
	logic [STATUS_W-1:0] res_status_d;
	logic [KEY_W-1:0]    res_vkey_d;
	logic [CNT_W-1:0]    count_d;
	logic [KEY_EXT_W-1:0] in_key_ext;
	logic [KEY_EXT_W-1:0] vkey_ext;
	logic [CNT_EXT_W-1:0] cnt_ext;

	assign idx_last   = (idx_q == IDX_W'(CAPACITY - 1));
	assign idx_step   = cmd.clear | cmd.scan_rd | cmd.upd_rd;
	assign rd_vld     = rdata_s1[WORD_W-1];
	assign rd_age     = rdata_s1[KEY_BITS +: AGE_W];
	assign rd_key     = rdata_s1[KEY_BITS-1:0];
	assign is_touch   = (op_q == OP_TOUCH);
	assign is_rem     = (op_q == OP_VICTIM) || (op_q == OP_ERASE);
	assign cnt_m1     = count_q - CNT_W'(1);
	assign vict_age   = cnt_m1[AGE_W-1:0];
	assign match      = rd_vld && ((op_q == OP_VICTIM) ? (rd_age == vict_age)
	                                                   : (rd_key == key_q));
	assign full       = (count_q == CNT_W'(CAPACITY));
	assign ins_ok     = !hit_q && free_q && !full;
	assign need_update = (is_touch && (hit_q || ins_ok)) || (is_rem && hit_q);
	assign in_key_ext = KEY_EXT_W'(req.key);
	assign vkey_ext   = KEY_EXT_W'(hit_key_q);
	assign cnt_ext    = CNT_EXT_W'(count_q);

	assign sts.idx_last    = idx_last;
	assign sts.need_update = need_update;
	assign sts.out_free    = !rsp_valid_q || rsp_ready;

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		new_vld = rd_vld;
		new_age = rd_age;
		new_key = rd_key;
		if (is_touch && hit_q) begin
			if (idx_s1 == hit_idx_q) begin
				new_age = '0;
			end else if (rd_vld && (rd_age < hit_age_q)) begin
				new_age = rd_age + AGE_W'(1);
			end
		end else if (is_touch) begin
			if (idx_s1 == free_idx_q) begin
				new_vld = 1'b1;
				new_age = '0;
				new_key = key_q;
			end else if (rd_vld) begin
				new_age = rd_age + AGE_W'(1);
			end
		end else begin
			if (idx_s1 == hit_idx_q) begin
				new_vld = 1'b0;
				new_age = '0;
			end else if (rd_vld && (rd_age > hit_age_q)) begin
				new_age = rd_age - AGE_W'(1);
			end
		end
	end

	always_comb begin
		res_status_d = ST_DONE;
		res_vkey_d   = '0;
		count_d      = count_q;
		if (is_touch) begin
			if (!hit_q && !ins_ok) begin
				res_status_d = ST_FULL;
			end else if (ins_ok) begin
				count_d = count_q + CNT_W'(1);
			end
		end else if (is_rem) begin
			if (!hit_q) begin
				res_status_d = ST_MISS;
			end else begin
				count_d = cnt_m1;
				if (op_q == OP_VICTIM) begin
					res_vkey_d = vkey_ext[KEY_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			mem[idx_q] <= '0;
		end else if (upd_s1) begin
			mem[idx_s1] <= {new_vld, new_age, new_key};
		end
		if (cmd.scan_rd || cmd.upd_rd) begin
			rdata_s1 <= mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			count_q     <= '0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			scan_s1     <= 1'b0;
			upd_s1      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			scan_s1 <= cmd.scan_rd;
			upd_s1  <= cmd.upd_rd;
			if (idx_step) begin
				idx_q <= idx_last ? '0 : idx_q + IDX_W'(1);
			end
			if (cmd.load_item) begin
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else if (scan_s1) begin
				if (match && !hit_q) begin
					hit_q <= 1'b1;
				end
				if (!rd_vld && !free_q) begin
					free_q <= 1'b1;
				end
			end
			if (cmd.decide) begin
				count_q <= count_d;
			end
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (cmd.load_item) begin
			op_q  <= req.op;
			key_q <= in_key_ext[KEY_BITS-1:0];
		end
		if (scan_s1 && match && !hit_q) begin
			hit_idx_q <= idx_s1;
			hit_age_q <= rd_age;
			hit_key_q <= rd_key;
		end
		if (scan_s1 && !rd_vld && !free_q) begin
			free_idx_q <= idx_s1;
		end
		if (cmd.decide) begin
			res_status_q <= res_status_d;
			res_vkey_q   <= res_vkey_d;
		end
		if (cmd.load_out) begin
			rsp_q.status     <= res_status_q;
			rsp_q.victim_key <= res_vkey_q;
			rsp_q.count      <= cnt_ext[COUNT_W-1:0];
		end
	end

endmodule

`default_nettype wire

/* src/lru_replacement_tracker_top.sv */
// Sequence: a request that changes entries takes a lookup scan and then an age update
// pass before its response beat; a miss, a full store or an unused operation skips the
// update pass. Only one request is in work at a time, and the entry memory is scanned
// once for lookup and once more for the age update.
// Reset: asynchronous; a sweep over every entry then clears the entry memory,
// during which no request is taken.
// ============================================================================
// LRU replacement tracker top level
// Tracks up to CAPACITY keys in least-recently-used order with touch, victim
// and erase operations.
// ============================================================================
`default_nettype none

module lru_replacement_tracker_top import lrt_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	lrt_cmd_t cmd;
	lrt_sts_t sts;

	lrt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lrt_dp #(
		.CAPACITY (CAPACITY),
		.KEY_BITS (KEY_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req       (req),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready)
	);

endmodule

`default_nettype wire

/* src/lrt_checker.sv */
// ============================================================================
// LRU tracker port checker
// Port-level properties of the tracker, bound to the top level.
// ============================================================================
`default_nettype none

module lrt_checker import lrt_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	// A stalled response beat must hold its value.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response beat changed while stalled");

	// Only one request is worked on at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in work");

	// A victim key is only reported by a successful operation.
	a_vkey_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_DONE) |-> rsp.victim_key == '0)
		else $error("victim key set on an unsuccessful response");

	// A dropped insert is only reported when the store is full.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_FULL) |-> rsp.count == COUNT_W'(CAPACITY))
		else $error("full status with store not full");

	// The unused status code never appears.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status == ST_DONE) || (rsp.status == ST_MISS) ||
		(rsp.status == ST_FULL))
		else $error("unknown status code");

endmodule

bind lru_replacement_tracker_top lrt_checker #(.CAPACITY(CAPACITY)) u_lrt_checker (.*);

`default_nettype wire
